FILE: rtl/fppa_pkg.sv
package fppa_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  data_mode;
    logic [31:0] listen_ip;
    logic [15:0] listen_port;
    logic [1:0]  data_command;
    logic        addr_updated;
  } out_beat_t;

  typedef enum logic [2:0] {
    PhIdle,
    PhParen,
    PhPort,
    PhPasv,
    PhDone
  } phase_e;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModePort = 2'd1;
  localparam logic [1:0] ModePasv = 2'd2;

  localparam logic [1:0] CmdNone = 2'd0;
  localparam logic [1:0] CmdList = 2'd1;
  localparam logic [1:0] CmdRetr = 2'd2;
  localparam logic [1:0] CmdStor = 2'd3;

  localparam int NumCand    = 5;
  localparam int PrefixMax  = 5;
  localparam int NumFields  = 6;
  localparam int CandPort   = 0;
  localparam int CandPasv   = 1;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  localparam logic [15:0] NumSat  = 16'hFFFF;
  localparam logic [7:0]  OctetMax = 8'd255;

  // "PORT ", "227", "LIST", "RETR ", "STOR "
  localparam logic [7:0] PrefixChar [NumCand][PrefixMax] = '{
    '{8'h50, 8'h4F, 8'h52, 8'h54, 8'h20},
    '{8'h32, 8'h32, 8'h37, 8'h00, 8'h00},
    '{8'h4C, 8'h49, 8'h53, 8'h54, 8'h00},
    '{8'h52, 8'h45, 8'h54, 8'h52, 8'h20},
    '{8'h53, 8'h54, 8'h4F, 8'h52, 8'h20}
  };

  localparam logic [2:0] PrefixLen [NumCand] = '{3'd5, 3'd3, 3'd4, 3'd5, 3'd5};

  localparam logic [1:0] PrefixCmd [NumCand] = '{CmdNone, CmdNone, CmdList, CmdRetr, CmdStor};

endpackage

FILE: rtl/ftp_port_pasv_address_parser.sv
// channel | signals                                 | beat
// in      | in_valid_i, in_ready_o, in_data_i       | one message byte, last mark
// out     | out_valid_o, out_ready_i, out_data_o    | one result per message
// one byte is taken per cycle while in_ready_o is high; its effect on the
// parse state and the result settle in that same cycle, the result coming
// from the output register in the cycle after the last byte of a message.
// input stalls only while a result is held and out_ready_i is low.
// reset clears the parse state, the stored address, mode and command.
module ftp_port_pasv_address_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fppa_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fppa_pkg::out_beat_t out_data_o
);

  logic [2:0]  pos_q, pos_d;
  logic [4:0]  flags_q, flags_d;
  fppa_pkg::phase_e phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] nums_q [fppa_pkg::NumFields];
  logic [15:0] nums_d [fppa_pkg::NumFields];
  logic        err_q, err_d;
  logic [2:0]  idx_q, idx_d;
  logic        seen_q, seen_d;
  logic        upd_q, upd_d;
  logic [1:0]  mode_q, mode_d;
  logic [31:0] ip_q, ip_d;
  logic [15:0] port_q, port_d;
  logic [1:0]  cmd_q, cmd_d;

  logic                out_valid_q, out_valid_d;
  fppa_pkg::out_beat_t res_q, res_d;

  logic        in_fire;
  logic [7:0]  b;
  logic        is_digit;
  logic [19:0] acc_mul;
  logic        fin;
  logic        ok;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign b           = in_data_i.data_byte;
  assign is_digit    = (b >= fppa_pkg::CharZero) && (b <= fppa_pkg::CharNine);
  assign acc_mul     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                     + {16'd0, b[3:0]};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_comb begin
    pos_d   = pos_q;
    flags_d = flags_q;
    phase_d = phase_q;
    acc_d   = acc_q;
    nums_d  = nums_q;
    err_d   = err_q;
    idx_d   = idx_q;
    seen_d  = seen_q;
    upd_d   = upd_q;
    mode_d  = mode_q;
    ip_d    = ip_q;
    port_d  = port_q;
    cmd_d   = cmd_q;
    res_d   = res_q;
    fin     = 1'b0;
    ok      = 1'b0;
    if (in_fire) begin
      if (phase_q == fppa_pkg::PhPort || phase_q == fppa_pkg::PhPasv) begin
        if (is_digit) begin
          acc_d  = (acc_mul > {4'd0, fppa_pkg::NumSat}) ? fppa_pkg::NumSat : acc_mul[15:0];
          seen_d = 1'b1;
        end else if (b == fppa_pkg::CharSpace && !seen_q) begin
          // skip leading space
        end else if (b == fppa_pkg::CharComma) begin
          if (!seen_q) begin
            err_d = 1'b1;
            fin   = 1'b1;
          end else begin
            if (idx_d < 3'(fppa_pkg::NumFields)) begin
              for (int k = 0; k < fppa_pkg::NumFields; k++) begin
                if (idx_d == 3'(k)) nums_d[k] = acc_d;
              end
              idx_d = idx_d + 3'd1;
            end
            acc_d  = '0;
            seen_d = 1'b0;
            if (idx_d == 3'(fppa_pkg::NumFields)) fin = 1'b1;
          end
        end else begin
          if (seen_d && idx_d < 3'(fppa_pkg::NumFields)) begin
            for (int k = 0; k < fppa_pkg::NumFields; k++) begin
              if (idx_d == 3'(k)) nums_d[k] = acc_d;
            end
            idx_d = idx_d + 3'd1;
          end
          acc_d  = '0;
          seen_d = 1'b0;
          fin    = 1'b1;
        end
      end else if (phase_q == fppa_pkg::PhParen) begin
        if (b == fppa_pkg::CharLParen) phase_d = fppa_pkg::PhPasv;
      end else if (pos_q < 3'(fppa_pkg::PrefixMax)) begin
        for (int c = 0; c < fppa_pkg::NumCand; c++) begin
          if (pos_q < fppa_pkg::PrefixLen[c] && flags_q[c]) begin
            if (b != fppa_pkg::PrefixChar[c][pos_q]) begin
              flags_d[c] = 1'b0;
            end else if (pos_q + 3'd1 == fppa_pkg::PrefixLen[c]) begin
              if (c == fppa_pkg::CandPort) begin
                phase_d = fppa_pkg::PhPort;
              end else if (c == fppa_pkg::CandPasv) begin
                phase_d = fppa_pkg::PhParen;
              end else if (mode_q != fppa_pkg::ModeNone) begin
                cmd_d = fppa_pkg::PrefixCmd[c];
              end
            end
          end
        end
      end

      if (pos_q != 3'd7) pos_d = pos_q + 3'd1;

      // message end closes an open address
      if (in_data_i.last_byte && !fin &&
          (phase_d == fppa_pkg::PhPort || phase_d == fppa_pkg::PhPasv)) begin
        if (seen_d && idx_d < 3'(fppa_pkg::NumFields)) begin
          for (int k = 0; k < fppa_pkg::NumFields; k++) begin
            if (idx_d == 3'(k)) nums_d[k] = acc_d;
          end
          idx_d = idx_d + 3'd1;
        end
        acc_d  = '0;
        seen_d = 1'b0;
        fin    = 1'b1;
      end

      if (fin) begin
        ok = (idx_d == 3'(fppa_pkg::NumFields)) && !err_d
          && (nums_d[0] <= {8'd0, fppa_pkg::OctetMax})
          && (nums_d[1] <= {8'd0, fppa_pkg::OctetMax})
          && (nums_d[2] <= {8'd0, fppa_pkg::OctetMax})
          && (nums_d[3] <= {8'd0, fppa_pkg::OctetMax});
        if (ok) begin
          ip_d   = {nums_d[0][7:0], nums_d[1][7:0], nums_d[2][7:0], nums_d[3][7:0]};
          port_d = {nums_d[4][7:0], 8'h00} + nums_d[5];
          mode_d = (phase_d == fppa_pkg::PhPort) ? fppa_pkg::ModePort : fppa_pkg::ModePasv;
          upd_d  = 1'b1;
        end
        phase_d = fppa_pkg::PhDone;
      end

      if (in_data_i.last_byte) begin
        res_d.data_mode    = mode_d;
        res_d.listen_ip    = ip_d;
        res_d.listen_port  = port_d;
        res_d.data_command = cmd_d;
        res_d.addr_updated = upd_d;
        pos_d   = '0;
        flags_d = '1;
        phase_d = fppa_pkg::PhIdle;
        acc_d   = '0;
        nums_d  = '{default: '0};
        err_d   = 1'b0;
        idx_d   = '0;
        seen_d  = 1'b0;
        upd_d   = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_fire && in_data_i.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      flags_q     <= '1;
      phase_q     <= fppa_pkg::PhIdle;
      acc_q       <= '0;
      nums_q      <= '{default: '0};
      err_q       <= 1'b0;
      idx_q       <= '0;
      seen_q      <= 1'b0;
      upd_q       <= 1'b0;
      mode_q      <= fppa_pkg::ModeNone;
      ip_q        <= '0;
      port_q      <= '0;
      cmd_q       <= fppa_pkg::CmdNone;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      flags_q     <= flags_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      nums_q      <= nums_d;
      err_q       <= err_d;
      idx_q       <= idx_d;
      seen_q      <= seen_d;
      upd_q       <= upd_d;
      mode_q      <= mode_d;
      ip_q        <= ip_d;
      port_q      <= port_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

FILE: dv/ftp_parse_monitor.sv
module ftp_parse_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  fppa_pkg::in_beat_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  fppa_pkg::out_beat_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_seen_o,
  output int                  updates_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KeyPort = 0;
  localparam int KeyPasv = 1;
  localparam int KeyList = 2;
  localparam int KeyRetr = 3;
  localparam int KeyStor = 4;
  localparam int NumKeys = 5;

  localparam logic [7:0] KeyText [NumKeys][5] = '{
    '{"P", "O", "R", "T", " "},
    '{"2", "2", "7", 8'h00, 8'h00},
    '{"L", "I", "S", "T", 8'h00},
    '{"R", "E", "T", "R", " "},
    '{"S", "T", "O", "R", " "}
  };
  localparam int KeyLen [NumKeys] = '{5, 3, 4, 5, 5};

  // per-message parse state
  logic [2:0]        pos;
  logic [4:0]        live;
  fppa_pkg::phase_e  phase;
  logic [15:0]       acc;
  logic [15:0]       nums [6];
  logic              perr;
  int                nidx;
  logic              seen_digit;
  logic              upd;

  // sticky data-connection state
  logic [1:0]  mode;
  logic [31:0] ip;
  logic [15:0] port;
  logic [1:0]  cmd;

  fppa_pkg::out_beat_t results_due [$];
  fppa_pkg::out_beat_t want;

  int fails = 0;
  int seen = 0;
  int ups = 0;
  int pending_cnt = 0;

  assign fail_count_o   = fails;
  assign pending_o      = pending_cnt;
  assign results_seen_o = seen;
  assign updates_o      = ups;

  task automatic start_message();
    pos = '0;
    live = '1;
    phase = fppa_pkg::PhIdle;
    acc = '0;
    foreach (nums[i]) nums[i] = '0;
    perr = 1'b0;
    nidx = 0;
    seen_digit = 1'b0;
    upd = 1'b0;
  endtask

  task automatic bank_number();
    if (seen_digit && nidx < 6) begin
      nums[nidx] = acc;
      nidx++;
    end
    acc = '0;
    seen_digit = 1'b0;
  endtask

  task automatic close_address();
    logic ok;
    ok = (nidx == 6) && !perr;
    for (int i = 0; i < 4; i++) begin
      if (nums[i] > 16'd255) ok = 1'b0;
    end
    if (ok) begin
      ip = {nums[0][7:0], nums[1][7:0], nums[2][7:0], nums[3][7:0]};
      port = {nums[4][7:0], 8'h00} + nums[5];
      mode = (phase == fppa_pkg::PhPort) ? fppa_pkg::ModePort : fppa_pkg::ModePasv;
      upd = 1'b1;
    end
    phase = fppa_pkg::PhDone;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [31:0]         v;
    fppa_pkg::out_beat_t r;
    if (phase == fppa_pkg::PhPort || phase == fppa_pkg::PhPasv) begin
      if (b >= "0" && b <= "9") begin
        v = acc * 32'd10 + {24'd0, b} - 32'd48;
        acc = (v > 32'd65535) ? 16'hFFFF : v[15:0];
        seen_digit = 1'b1;
      end else if (b == " " && !seen_digit) begin
        // leading blank before a number
      end else if (b == ",") begin
        if (!seen_digit) begin
          perr = 1'b1;
          close_address();
        end else begin
          bank_number();
          if (nidx >= 6) close_address();
        end
      end else begin
        bank_number();
        close_address();
      end
    end else if (phase == fppa_pkg::PhParen) begin
      if (b == "(") phase = fppa_pkg::PhPasv;
    end else if (pos < 3'd5) begin
      for (int k = 0; k < NumKeys; k++) begin
        if (pos < KeyLen[k] && live[k]) begin
          if (b != KeyText[k][pos]) begin
            live[k] = 1'b0;
          end else if (pos + 1 == KeyLen[k]) begin
            case (k)
              KeyPort: phase = fppa_pkg::PhPort;
              KeyPasv: phase = fppa_pkg::PhParen;
              KeyList: if (mode != fppa_pkg::ModeNone) cmd = fppa_pkg::CmdList;
              KeyRetr: if (mode != fppa_pkg::ModeNone) cmd = fppa_pkg::CmdRetr;
              KeyStor: if (mode != fppa_pkg::ModeNone) cmd = fppa_pkg::CmdStor;
              default: ;
            endcase
          end
        end
      end
    end
    if (pos < 3'd7) pos++;
    if (last) begin
      if (phase == fppa_pkg::PhPort || phase == fppa_pkg::PhPasv) begin
        bank_number();
        close_address();
      end
      r.data_mode = mode;
      r.listen_ip = ip;
      r.listen_port = port;
      r.data_command = cmd;
      r.addr_updated = upd;
      results_due.push_back(r);
      start_message();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_message();
      mode = fppa_pkg::ModeNone;
      ip = '0;
      port = '0;
      cmd = fppa_pkg::CmdNone;
      results_due.delete();
      pending_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (results_due.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, got %h", $time, out_data_i);
        end else begin
          want = results_due.pop_front();
          compare_field("data_mode", 32'(want.data_mode), 32'(out_data_i.data_mode));
          compare_field("listen_ip", want.listen_ip, out_data_i.listen_ip);
          compare_field("listen_port", 32'(want.listen_port), 32'(out_data_i.listen_port));
          compare_field("data_command", 32'(want.data_command),
                        32'(out_data_i.data_command));
          compare_field("addr_updated", 32'(want.addr_updated),
                        32'(out_data_i.addr_updated));
          if (want.addr_updated) ups++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        absorb_byte(in_data_i.data_byte, in_data_i.last_byte);
      end
      pending_cnt = results_due.size();
    end
  end

endmodule

FILE: dv/tb_ftp_port_pasv_address_parser.sv
module tb_ftp_port_pasv_address_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CarRet   = 8'h0D;
  localparam logic [7:0] LineFeed = 8'h0A;
  localparam int HoldCycles = 250;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  fppa_pkg::in_beat_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  fppa_pkg::out_beat_t out_data_o;

  int fail_count;
  int pending;
  int results_seen;
  int updates;

  logic [7:0] msg_bytes [$];
  int bytes_sent = 0;
  int msgs_sent = 0;
  logic hold_out = 1'b0;

  always #4 clk_i = ~clk_i;

  ftp_port_pasv_address_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  ftp_parse_monitor u_mon (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen),
    .updates_o      (updates)
  );

  // 0 busy stretch, 1 light gaps, 2 heavy gaps
  function automatic int draw_wait(input int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic int pick_num();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      2: return $urandom_range(256, 99999);
      3: return $urandom_range(0, 9);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic put_num(input int v);
    put_text($sformatf("%0d", v));
  endtask

  task automatic put_crlf();
    msg_bytes.push_back(CarRet);
    msg_bytes.push_back(LineFeed);
  endtask

  task automatic ship();
    int style;
    int gap;
    style = $urandom_range(0, 2);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      gap = draw_wait(style);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_data_i.data_byte <= msg_bytes[i];
      in_data_i.last_byte <= (i == msg_bytes.size() - 1);
      in_valid_i <= 1'b1;
      do @(posedge clk_i); while (!in_ready_o);
      bytes_sent++;
    end
    msgs_sent++;
    msg_bytes.delete();
  endtask

  task automatic say(input string s);
    put_text(s);
    ship();
  endtask

  task automatic rand_address(input bit pasv);
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 6;
    if (pasv) begin
      put_text("227 ");
      if ($urandom_range(0, 1)) put_text("Entering Passive Mode ");
      if ($urandom_range(0, 9) != 0) put_text("(");
    end else begin
      put_text("PORT ");
    end
    for (int j = 0; j < n; j++) begin
      if (j > 0) put_text(",");
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_text(" ");
      if ($urandom_range(0, 19) != 0) put_num(pick_num());
    end
    case ($urandom_range(0, 3))
      0: ;
      1: put_text(")");
      2: put_crlf();
      default: begin
        put_text(").");
        put_crlf();
      end
    endcase
    ship();
  endtask

  task automatic rand_command();
    case ($urandom_range(0, 2))
      0: put_text("LIST");
      1: put_text("RETR ");
      default: put_text("STOR ");
    endcase
    repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom_range(33, 126)));
    if ($urandom_range(0, 1)) put_crlf();
    ship();
  endtask

  task automatic rand_broken();
    string s;
    int cut;
    case ($urandom_range(0, 4))
      0: s = "PORT ";
      1: s = "227";
      2: s = "LIST";
      3: s = "RETR ";
      default: s = "STOR ";
    endcase
    cut = $urandom_range(0, s.len() - 1);
    for (int i = 0; i < cut; i++) msg_bytes.push_back(s[i]);
    if ($urandom_range(0, 1)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    if (msg_bytes.size() == 0 || $urandom_range(0, 1)) put_text("1,2,3,4,5,6");
    ship();
  endtask

  task automatic rand_noise();
    repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    ship();
  endtask

  initial begin
    int stall;
    int rx_style;
    int rx_left;
    rx_left = 0;
    rx_style = 0;
    wait (rst_ni);
    forever begin
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = 16;
      end
      rx_left--;
      stall = draw_wait(rx_style);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // command before any mode is set
    say("LIST");
    say("PORT 10,0,0,1,4,1");
    say("RETR readme");
    say("227 Entering Passive Mode (192,168,1,2,255,255).");
    say("STOR up");
    say("LIST");
    // incomplete, oversize octet, empty number, saturation
    say("PORT ");
    say("PORT 1,2,3,256,0,0");
    say("PORT 1,,2,3,4,5");
    say("PORT 0,0,0,0,99999,99999");
    say("PORT  255, 255,255,255,0,0");
    say("PORT 1,2,3,4,5");
    say("PORT 1,2,3,4,5,6,7");
    say("PORT 1,2,3,4,5,6x");
    say("PO");
    say("227 no address");
    msg_bytes.push_back(8'hFF);
    ship();
    msg_bytes.push_back(8'h00);
    ship();

    // long receiver stall while short messages keep coming
    hold_out = 1'b1;
    repeat (10) say("LIST");

    while (bytes_sent < 450) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: rand_address(1'b0);
        7, 8, 9, 10:         rand_address(1'b1);
        11, 12, 13, 14, 15:  rand_command();
        16, 17:              rand_broken();
        default:             rand_noise();
      endcase
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("run covered %0d bytes in %0d messages", bytes_sent, msgs_sent);
    $display("%0d results checked, %0d of them set a new address", results_seen, updates);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/fppa_pkg.sv
rtl/ftp_port_pasv_address_parser.sv
dv/ftp_parse_monitor.sv
dv/tb_ftp_port_pasv_address_parser.sv
